// ===== src/lnws_pkg.sv =====
`timescale 1ns / 1ps
package lnws_pkg;

  // Request codes on cmd
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_HALF   = 3'd1;
  localparam logic [2:0] CMD_FULL   = 3'd2;
  localparam logic [2:0] CMD_DATA   = 3'd3;
  localparam logic [2:0] CMD_CURSOR = 3'd4;
  localparam logic [2:0] CMD_NUMBER = 3'd5;
  localparam logic [2:0] CMD_STRING = 3'd6;

  localparam int LINE_LENGTH_DEF = 16;
  localparam int TOTAL_CHARS_DEF = 32;
  localparam int MAX_DIGITS      = 10;
  localparam int NUM_W           = 31;
  localparam int BCD_W           = 4 * MAX_DIGITS;
  localparam int INIT_STEPS      = 8;
  localparam int INIT_STEP_W     = $clog2(INIT_STEPS);

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] SET_DDRAM  = 8'h80;

  // One byte handed to the nibble stage
  typedef struct packed {
    logic       valid;
    logic       rs;
    logic       half;
    logic       last;
    logic [7:0] value;
  } byte_req_t;

  // Control from the sequencer to the decimal converter
  typedef struct packed {
    logic start;
    logic shift;
  } bcd_ctrl_t;

  typedef struct packed {
    logic       half;
    logic [7:0] value;
  } init_entry_t;

  // Power-up sequence: three half commands, then five full commands
  function automatic init_entry_t init_entry(input logic [INIT_STEP_W-1:0] step);
    init_entry_t e;
    unique case (step)
      3'd0:    e = '{half: 1'b1, value: 8'h30};
      3'd1:    e = '{half: 1'b1, value: 8'h30};
      3'd2:    e = '{half: 1'b1, value: 8'h20};
      3'd3:    e = '{half: 1'b0, value: 8'h28};
      3'd4:    e = '{half: 1'b0, value: 8'h0C};
      3'd5:    e = '{half: 1'b0, value: 8'h01};
      3'd6:    e = '{half: 1'b0, value: 8'h06};
      default: e = '{half: 1'b0, value: SET_DDRAM};
    endcase
    return e;
  endfunction

  // Cursor placement command for a line and column
  function automatic logic [7:0] cursor_byte(input logic [7:0] line, input logic [7:0] col,
                                             input logic [7:0] line_len);
    logic [7:0] addr;
    unique case (line)
      8'd1:    addr = 8'h40;
      8'd2:    addr = 8'h10;
      8'd3:    addr = 8'h50;
      default: addr = 8'h00;
    endcase
    if (col <= line_len) begin
      addr = addr + col;
    end
    return SET_DDRAM | {1'b0, addr[6:0]};
  endfunction

endpackage

// ===== src/lnws_bcd.sv =====
`timescale 1ns / 1ps
module lnws_bcd
  import lnws_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  bcd_ctrl_t        ctrl,
  input  logic [NUM_W-1:0] value,
  output logic             busy,
  output logic [3:0]       digit
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] adj;
  logic [NUM_W-1:0] bin;
  logic [CNT_W-1:0] cnt;

  // Add three to every digit of five or more before the next shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[4*i +: 4] = bcd[4*i +: 4] + ((bcd[4*i +: 4] >= 4'd5) ? 4'd3 : 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bcd <= '0;
      bin <= value;
    end else if (busy) begin
      bcd <= {adj[BCD_W-2:0], bin[NUM_W-1]};
      bin <= {bin[NUM_W-2:0], 1'b0};
    end else if (ctrl.shift) begin
      bcd <= {bcd[BCD_W-5:0], 4'b0000};
    end
  end

  assign digit = bcd[BCD_W-1 -: 4];

endmodule

// ===== src/lnws_nib_out.sv =====
`timescale 1ns / 1ps
module lnws_nib_out
  import lnws_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  byte_req_t  req,
  output logic       byte_ready,
  input  logic       out_stall,
  output logic       out_valid,
  output logic       register_select,
  output logic [3:0] data_nibble,
  output logic       last
);

  logic [1:0] cnt;
  logic [7:0] shreg;
  logic       rs;
  logic       last_flag;
  logic       out_accept;

  assign out_valid       = (cnt != 2'd0);
  assign out_accept      = out_valid && !out_stall;
  assign byte_ready      = (cnt == 2'd0) || ((cnt == 2'd1) && out_accept);
  assign register_select = rs;
  assign data_nibble     = shreg[7:4];
  assign last            = last_flag && (cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (req.valid && byte_ready) begin
      cnt <= req.half ? 2'd1 : 2'd2;
    end else if (out_accept) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Upper nibble first; advance by one nibble per delivered strobe
  always_ff @(posedge clk) begin
    if (req.valid && byte_ready) begin
      shreg     <= req.value;
      rs        <= req.rs;
      last_flag <= req.last;
    end else if (out_accept) begin
      shreg <= {shreg[3:0], 4'b0000};
    end
  end

endmodule

// ===== src/lcd_nibble_write_sequencer_core.sv =====
`timescale 1ns / 1ps
// First strobe: after the state leaves idle and the nibble stage loads the byte.
// Throughput: one strobe per cycle while out_stall is low; one item at a time, the next taken once the
//   previous one has handed its last byte to the nibble stage.
// Number items run a bit-serial decimal conversion first; leading zeros are then
//   skipped and the remaining digits printed.
// Reset (rst, synchronous): string count 0, wrap line 255, all channels empty.
module lcd_nibble_write_sequencer_core
  import lnws_pkg::*;
#(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF,
  parameter int TOTAL_CHARS = TOTAL_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [7:0]  byte_value,
  input  logic [7:0]  line_index,
  input  logic [7:0]  column,
  input  logic [30:0] number_value,
  input  logic        wrap_enable,
  input  logic        string_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        register_select,
  output logic [3:0]  data_nibble,
  output logic        last
);

  localparam int SC_W = $clog2(TOTAL_CHARS + 1);
  localparam int LP_W = $clog2(LINE_LENGTH);
  localparam int DC_W = $clog2(MAX_DIGITS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INIT   = 5'b00010,
    S_SEND   = 5'b00100,
    S_CONV   = 5'b01000,
    S_DIGITS = 5'b10000
  } state_t;

  state_t state;

  // String state: count of characters and position within the current line
  logic [SC_W-1:0] string_count;
  logic [LP_W-1:0] line_pos;
  logic [7:0]      current_line;

  // Up to two queued bytes for the simple requests and wrapped characters
  logic [7:0] b0, b1;
  logic       rs0, rs1, half0, q_two;

  logic [INIT_STEP_W-1:0] step;
  logic [DC_W-1:0]        dcnt;
  logic                   seen;

  byte_req_t   req;
  logic        byte_ready;
  logic        req_accept;
  bcd_ctrl_t   bcd_ctrl;
  logic        bcd_busy;
  logic [3:0]  digit;
  logic        in_accept;
  logic        skip;
  init_entry_t ie;

  // String bookkeeping seen through a possible string start
  logic [SC_W-1:0] sc_eff;
  logic [LP_W-1:0] lp_eff;
  logic [LP_W-1:0] lp_step;
  logic [7:0]      cl_eff;
  logic [7:0]      cl_inc;
  logic            str_emit;
  logic            str_wrap;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign req_accept = req.valid && byte_ready;
  assign ie         = init_entry(step);

  always_comb begin
    sc_eff   = string_start ? '0 : string_count;
    lp_eff   = string_start ? '0 : line_pos;
    cl_eff   = string_start ? 8'hFF : current_line;
    cl_inc   = cl_eff + 8'd1;
    lp_step  = (lp_eff == LP_W'(LINE_LENGTH - 1)) ? '0 : lp_eff + 1'b1;
    str_emit = (byte_value != 8'd0) && (sc_eff < SC_W'(TOTAL_CHARS));
    str_wrap = str_emit && wrap_enable && (lp_eff == '0);
  end

  // Leading zeros are dropped, but the final digit always prints
  assign skip = (digit == 4'd0) && !seen && (dcnt != DC_W'(MAX_DIGITS - 1));

  // Byte request toward the nibble stage
  always_comb begin
    req = '0;
    unique case (state)
      S_INIT: begin
        req.valid = 1'b1;
        req.half  = ie.half;
        req.value = ie.value;
        req.last  = (step == INIT_STEP_W'(INIT_STEPS - 1));
      end
      S_SEND: begin
        req.valid = 1'b1;
        req.rs    = rs0;
        req.half  = half0;
        req.value = b0;
        req.last  = !q_two;
      end
      S_DIGITS: begin
        req.valid = !skip;
        req.rs    = 1'b1;
        req.value = ASCII_ZERO | {4'b0000, digit};
        req.last  = (dcnt == DC_W'(MAX_DIGITS - 1));
      end
      default: req = '0;
    endcase
  end

  always_comb begin
    bcd_ctrl.start = in_accept && (cmd == CMD_NUMBER);
    bcd_ctrl.shift = (state == S_DIGITS) && (skip || req_accept);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      string_count <= '0;
      line_pos     <= '0;
      current_line <= 8'hFF;
      step         <= '0;
      dcnt         <= '0;
      seen         <= 1'b0;
      q_two        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            unique case (cmd)
              CMD_INIT: begin
                step  <= '0;
                state <= S_INIT;
              end
              CMD_HALF, CMD_FULL, CMD_DATA, CMD_CURSOR: begin
                q_two <= 1'b0;
                state <= S_SEND;
              end
              CMD_NUMBER: begin
                state <= S_CONV;
              end
              CMD_STRING: begin
                string_count <= (byte_value == 8'd0) ? SC_W'(TOTAL_CHARS) :
                                str_emit ? sc_eff + 1'b1 : sc_eff;
                line_pos     <= str_emit ? lp_step : lp_eff;
                current_line <= str_wrap ? cl_inc : cl_eff;
                q_two        <= str_wrap;
                state        <= str_emit ? S_SEND : S_IDLE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_INIT: begin
          if (req_accept) begin
            step <= step + 1'b1;
            if (req.last) begin
              state <= S_IDLE;
            end
          end
        end
        S_SEND: begin
          if (req_accept) begin
            if (q_two) begin
              q_two <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_CONV: begin
          if (!bcd_busy) begin
            dcnt  <= '0;
            seen  <= 1'b0;
            state <= S_DIGITS;
          end
        end
        S_DIGITS: begin
          if (skip) begin
            dcnt <= dcnt + 1'b1;
          end else if (req_accept) begin
            seen <= 1'b1;
            dcnt <= dcnt + 1'b1;
            if (req.last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Queue payload: load on acceptance, advance after the first byte goes out
  always_ff @(posedge clk) begin
    if (in_accept) begin
      half0 <= (cmd == CMD_HALF);
      rs1   <= 1'b1;
      b1    <= byte_value;
      unique case (cmd)
        CMD_HALF, CMD_FULL: begin
          b0  <= byte_value;
          rs0 <= 1'b0;
        end
        CMD_CURSOR: begin
          b0  <= cursor_byte(line_index, column, 8'(LINE_LENGTH));
          rs0 <= 1'b0;
        end
        CMD_STRING: begin
          if (str_wrap) begin
            b0  <= cursor_byte(cl_inc, 8'd0, 8'(LINE_LENGTH));
            rs0 <= 1'b0;
          end else begin
            b0  <= byte_value;
            rs0 <= 1'b1;
          end
        end
        default: begin
          b0  <= byte_value;
          rs0 <= 1'b1;
        end
      endcase
    end else if ((state == S_SEND) && req_accept && q_two) begin
      b0    <= b1;
      rs0   <= rs1;
      half0 <= 1'b0;
    end
  end

  lnws_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (bcd_ctrl),
    .value (number_value),
    .busy  (bcd_busy),
    .digit (digit)
  );

  lnws_nib_out u_nib (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .byte_ready      (byte_ready),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .register_select (register_select),
    .data_nibble     (data_nibble),
    .last            (last)
  );

  // Digits are only read once conversion has finished
  a_digits_after_conv: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGITS) |-> !bcd_busy)
    else $error("digit read while conversion running");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    string_count <= SC_W'(TOTAL_CHARS))
    else $error("string count beyond total characters");

  a_line_pos_bound: assert property (@(posedge clk) disable iff (rst)
    line_pos <= LP_W'(LINE_LENGTH - 1))
    else $error("line position beyond line length");

  // A number item always leaves idle for conversion first
  a_conv_follows_start: assert property (@(posedge clk) disable iff (rst)
    bcd_ctrl.start |=> (state == S_CONV) && bcd_busy)
    else $error("conversion did not start");

endmodule
